@@ rtl/ctt_pkg.sv @@
// Shared types, codes and helper functions for the config text tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ctt_pkg;

  localparam int unsigned CTT_FIFO_DEPTH = 4;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  // input item kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;

  // result kinds
  localparam logic [1:0] RK_BYTE   = 2'd0;
  localparam logic [1:0] RK_TOKEN  = 2'd1;
  localparam logic [1:0] RK_ERROR  = 2'd2;
  localparam logic [1:0] RK_FINISH = 2'd3;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BSLSH = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    MODE_SKIP    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_BARE    = 3'd2,
    MODE_QUOTED  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_DONE    = 3'd5
  } mode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] in_byte;
  } ctt_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic [23:0] line_number;
    logic        last;
  } ctt_out_t;

  // results of one item, handed from the lexer to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    ctt_out_t   r0;
    ctt_out_t   r1;
  } ctt_push_t;

  // C-locale isspace
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // {valid, decoded byte} for the character after a backslash
  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_BSLSH: r = {1'b1, CH_BSLSH};
      CH_ZERO:  r = {1'b1, CH_NUL};
      CH_QUOTE: r = {1'b1, CH_QUOTE};
      CH_R:     r = {1'b1, CH_CR};
      CH_N:     r = {1'b1, CH_NL};
      CH_T:     r = {1'b1, CH_TAB};
      default:  r = {1'b0, CH_NUL};
    endcase
    return r;
  endfunction

endpackage

@@ rtl/config_text_tokenizer_top.sv @@
// Top level of the config text tokenizer: lexer plus result queue.
// Depends on ctt_pkg, ctt_lexer and ctt_out_fifo.
//
//  channel | ports                          | word
//  --------+--------------------------------+--------------------------------
//  input   | in_valid, in_ready, in_data    | kind, in_byte
//  result  | out_valid, out_ready, out_data | result_kind, out_byte,
//          |                                |   line_number, last
//
// One input word is taken per cycle while in_ready is high; its zero to two
// results are written into the result queue in the same cycle and leave
// one per cycle while out_ready is high. Only the end-of-input word yields
// two results, and the queue absorbs it without stalling an always-ready
// receiver. in_ready drops while the queue has room for fewer than two
// results. Synchronous reset sets mode to skipping, line count to one and
// empties the queue.
`timescale 1ns / 1ps

module config_text_tokenizer_top import ctt_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = CTT_FIFO_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ctt_out_t out_data
);

  ctt_push_t push;
  logic      room2;
  logic      acc;

  assign in_ready = room2;
  assign acc      = in_valid && in_ready;

  ctt_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_data),
    .push  (push)
  );

  ctt_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/ctt_lexer.sv @@
// Lexer state (mode and line count) and the per-word decode into results.
// Depends on ctt_pkg.
`timescale 1ns / 1ps

module ctt_lexer import ctt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  ctt_in_t   item,
  output ctt_push_t push
);

  mode_t       mode_r, mode_nxt;
  logic [23:0] line_r, line_nxt;
  logic        bump;
  logic [1:0]  n;
  logic [1:0]  k0;
  logic [7:0]  b0;
  logic [8:0]  esc;

  always_comb begin
    mode_nxt = mode_r;
    bump     = 1'b0;
    n        = 2'd0;
    k0       = RK_BYTE;
    b0       = CH_NUL;
    esc      = esc_decode(item.in_byte);
    if (mode_r == MODE_DONE) begin
      n  = 2'd1;
      k0 = RK_FINISH;
    end else if (item.kind == KIND_DATA) begin
      case (mode_r)
        MODE_SKIP: begin
          if (item.in_byte == CH_HASH) begin
            mode_nxt = MODE_COMMENT;
          end else if (item.in_byte == CH_NL) begin
            bump = 1'b1;
          end else if (is_space(item.in_byte)) begin
            mode_nxt = MODE_SKIP;
          end else if (item.in_byte == CH_QUOTE) begin
            mode_nxt = MODE_QUOTED;
          end else begin
            n        = 2'd1;
            b0       = item.in_byte;
            mode_nxt = MODE_BARE;
          end
        end
        MODE_COMMENT: begin
          if (item.in_byte == CH_NL) begin
            bump     = 1'b1;
            mode_nxt = MODE_SKIP;
          end
        end
        MODE_BARE: begin
          n = 2'd1;
          if (is_space(item.in_byte)) begin
            k0       = RK_TOKEN;
            bump     = (item.in_byte == CH_NL);
            mode_nxt = MODE_SKIP;
          end else begin
            b0 = item.in_byte;
          end
        end
        MODE_QUOTED: begin
          if (item.in_byte == CH_BSLSH) begin
            mode_nxt = MODE_ESCAPE;
          end else if (item.in_byte == CH_NL) begin
            n        = 2'd1;
            k0       = RK_ERROR;
            mode_nxt = MODE_SKIP;
          end else if (item.in_byte == CH_QUOTE) begin
            n        = 2'd1;
            k0       = RK_TOKEN;
            mode_nxt = MODE_SKIP;
          end else begin
            n  = 2'd1;
            b0 = item.in_byte;
          end
        end
        MODE_ESCAPE: begin
          n = 2'd1;
          if (esc[8]) begin
            b0       = esc[7:0];
            mode_nxt = MODE_QUOTED;
          end else begin
            k0       = RK_ERROR;
            mode_nxt = MODE_SKIP;
          end
        end
        default: begin
          mode_nxt = MODE_SKIP;
        end
      endcase
    end else if (item.kind == KIND_END) begin
      // open token gets closed (or flagged) ahead of the finished marker
      if (mode_r == MODE_BARE) begin
        n  = 2'd2;
        k0 = RK_TOKEN;
      end else if (mode_r == MODE_QUOTED || mode_r == MODE_ESCAPE) begin
        n  = 2'd2;
        k0 = RK_ERROR;
      end else begin
        n  = 2'd1;
        k0 = RK_FINISH;
      end
      mode_nxt = MODE_DONE;
    end else begin
      n        = 2'd1;
      k0       = RK_ERROR;
      mode_nxt = MODE_SKIP;
    end
    line_nxt = (bump && line_r != LINE_MAX) ? line_r + 24'd1 : line_r;
  end

  always_comb begin
    push.cnt            = acc ? n : 2'd0;
    push.r0.result_kind = k0;
    push.r0.out_byte    = b0;
    push.r0.line_number = line_nxt;
    push.r0.last        = (n == 2'd1);
    push.r1.result_kind = RK_FINISH;
    push.r1.out_byte    = CH_NUL;
    push.r1.line_number = line_nxt;
    push.r1.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SKIP;
      line_r <= 24'd1;
    end else if (acc) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DONE) |=> (mode_r == MODE_DONE))
    else $error("lexer left done mode");
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 24'd0)
    else $error("line count reached zero");
  a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(line_r))
    else $error("line count moved without an accepted word");
`endif

endmodule

@@ rtl/ctt_out_fifo.sv @@
// Result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
// Depends on ctt_pkg.
`timescale 1ns / 1ps

module ctt_out_fifo import ctt_pkg::*; #(
  parameter int unsigned DEPTH = CTT_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctt_push_t push,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_ready,
  output ctt_out_t  out_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_ROOM = CW'(DEPTH - 2);

  ctt_out_t      mem [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr1;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_r];
  assign room2     = (count_r <= CNT_ROOM);
  assign pop       = out_valid && out_ready;
  assign wr1       = inc(wr_r);

  always_comb begin
    wr_nxt    = (push.cnt == 2'd2) ? inc(wr1) : (push.cnt == 2'd1) ? wr1 : wr_r;
    rd_nxt    = pop ? inc(rd_r) : rd_r;
    count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room2)
    else $error("push into a full result queue");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && push.cnt == 2'd0) |=> !out_valid)
    else $error("result shown from an empty queue");
`endif

endmodule
